@@ rtl/core/vqsm_pkg.sv @@
package vqsm_pkg;

    localparam int VOICES_DEF    = 8;
    localparam int ADDR_BITS_DEF = 20;

    localparam int SLOTS      = 8;
    localparam int CNT_W      = 4;
    localparam int ADDR_OUT_W = 20;
    localparam int LEN_W      = 32;
    localparam int SAMPLE_W   = 8;
    localparam int MIX_W      = 8;
    localparam int SUM_W      = 12;

    localparam int IN_FIELDS_W  = ADDR_OUT_W + LEN_W + SLOTS * SAMPLE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = MIX_W + CNT_W + SLOTS * ADDR_OUT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int MID_LEVEL = 128;
    localparam int TOP_LEVEL = 255;
    localparam int MIN_LEN   = 2;

    localparam logic MODE_PLAY = 1'b0;
    localparam logic MODE_MIX  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

@@ rtl/core/vqsm_ctrl.sv @@
module vqsm_ctrl
    import vqsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // output register must be free or draining this cycle
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.exec)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/core/vqsm_datapath.sv @@
module vqsm_datapath
    import vqsm_pkg::*;
#(
    parameter int VOICES    = VOICES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic signed [SUM_W-1:0] SUM_MID = SUM_W'(MID_LEVEL);
    localparam logic signed [SUM_W-1:0] SUM_TOP = SUM_W'(TOP_LEVEL);

    // input beat
    logic                       mode_reg;
    logic [ADDR_OUT_W-1:0]      start_reg;
    logic [LEN_W-1:0]           len_reg;
    logic signed [SAMPLE_W-1:0] sample_reg [SLOTS];

    // voice table
    logic [ADDR_BITS-1:0] addr_reg [VOICES];
    logic [LEN_W-1:0]     rem_reg  [VOICES];
    logic [CNT_W-1:0]     count_reg;

    // result
    logic [MIX_W-1:0]      mixed_reg;
    logic [CNT_W-1:0]      active_reg;
    logic [ADDR_OUT_W-1:0] fetch_reg [SLOTS];

    logic [ADDR_BITS-1:0]       cur_addr   [SLOTS];
    logic [LEN_W-1:0]           cur_rem    [SLOTS];
    logic                       keep       [SLOTS];
    logic [CNT_W-1:0]           pos        [SLOTS];
    logic [CNT_W-1:0]           run_cnt;
    logic signed [SUM_W-1:0]    sum_acc;
    logic [MIX_W-1:0]           mix_value;
    logic [ADDR_BITS-1:0]       mix_addr   [SLOTS];
    logic [LEN_W-1:0]           mix_rem    [SLOTS];
    logic                       len_ok;
    logic                       full;
    logic [CNT_W-1:0]           base_cnt;
    logic [ADDR_BITS-1:0]       play_addr  [SLOTS];
    logic [LEN_W-1:0]           play_rem   [SLOTS];
    logic [CNT_W-1:0]           play_count;
    logic [ADDR_BITS-1:0]       addr_next  [SLOTS];
    logic [LEN_W-1:0]           rem_next   [SLOTS];
    logic [CNT_W-1:0]           count_next;
    logic [MIX_W-1:0]           mixed_next;
    logic [ADDR_OUT_W-1:0]      fetch_next [SLOTS];

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cur
        if (g < VOICES)
        begin : g_live
            assign cur_addr[g] = addr_reg[g];
            assign cur_rem[g]  = rem_reg[g];
        end
        else
        begin : g_none
            assign cur_addr[g] = '0;
            assign cur_rem[g]  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= s_tuser;
            start_reg <= s_tdata[ADDR_OUT_W-1:0];
            len_reg   <= s_tdata[ADDR_OUT_W +: LEN_W];
            for (int k = 0; k < SLOTS; k++)
                sample_reg[k] <= s_tdata[ADDR_OUT_W + LEN_W + k * SAMPLE_W +: SAMPLE_W];
        end
    end

    // mix: sum of active slots, then step, count down and compact survivors
    always_comb
    begin
        sum_acc = SUM_MID;
        run_cnt = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < VOICES && CNT_W'(i) < count_reg)
                sum_acc = sum_acc + SUM_W'(sample_reg[i]);
            keep[i] = (i < VOICES) && (CNT_W'(i) < count_reg) && (cur_rem[i] != LEN_W'(1));
            pos[i]  = run_cnt;
            if (keep[i])
                run_cnt = run_cnt + CNT_W'(1);
        end

        if (sum_acc < 0)
            mix_value = '0;
        else if (sum_acc > SUM_TOP)
            mix_value = MIX_W'(TOP_LEVEL);
        else
            mix_value = sum_acc[MIX_W-1:0];

        for (int j = 0; j < SLOTS; j++)
        begin
            mix_addr[j] = cur_addr[j];
            mix_rem[j]  = cur_rem[j];
            for (int i = 0; i < SLOTS; i++)
            begin
                if (keep[i] && pos[i] == CNT_W'(j))
                begin
                    mix_addr[j] = cur_addr[i] + ADDR_BITS'(1);
                    mix_rem[j]  = cur_rem[i] - LEN_W'(1);
                end
            end
        end
    end

    // play: for lengths of at least 2, drop oldest when full and append at the end
    always_comb
    begin
        len_ok   = len_reg >= LEN_W'(MIN_LEN);
        full     = count_reg >= CNT_W'(VOICES);
        base_cnt = full ? count_reg - CNT_W'(1) : count_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            play_addr[i] = cur_addr[i];
            play_rem[i]  = cur_rem[i];
            if (len_ok)
            begin
                if (full && i < SLOTS - 1)
                begin
                    play_addr[i] = cur_addr[i+1];
                    play_rem[i]  = cur_rem[i+1];
                end
                if (base_cnt == CNT_W'(i))
                begin
                    play_addr[i] = ADDR_BITS'(start_reg);
                    play_rem[i]  = len_reg - LEN_W'(1);
                end
            end
        end
        play_count = len_ok ? base_cnt + CNT_W'(1) : count_reg;
    end

    always_comb
    begin
        if (mode_reg == MODE_MIX)
        begin
            count_next = run_cnt;
            mixed_next = mix_value;
        end
        else
        begin
            count_next = play_count;
            mixed_next = MIX_W'(MID_LEVEL);
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            addr_next[k] = (mode_reg == MODE_MIX) ? mix_addr[k] : play_addr[k];
            rem_next[k]  = (mode_reg == MODE_MIX) ? mix_rem[k]  : play_rem[k];
            if (k < VOICES && CNT_W'(k) < count_next)
                fetch_next[k] = ADDR_OUT_W'(addr_next[k]);
            else
                fetch_next[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int k = 0; k < VOICES; k++)
            begin
                addr_reg[k] <= addr_next[k];
                rem_reg[k]  <= rem_next[k];
            end
            mixed_reg  <= mixed_next;
            active_reg <= count_next;
            for (int k = 0; k < SLOTS; k++)
                fetch_reg[k] <= fetch_next[k];
        end
    end

    always_comb
    begin
        m_tdata                = '0;
        m_tdata[MIX_W-1:0]     = mixed_reg;
        m_tdata[MIX_W +: CNT_W] = active_reg;
        for (int k = 0; k < SLOTS; k++)
            m_tdata[MIX_W + CNT_W + k * ADDR_OUT_W +: ADDR_OUT_W] = fetch_reg[k];
    end

endmodule

@@ rtl/core/voice_queue_sample_mixer_unit.sv @@
// Voice queue sample mixer. Keeps an ordered table of up to VOICES playing sounds.
// A beat with tuser = 0 starts a voice at start_address playing length-1 samples
// (lengths below 2 are ignored; a full table drops its oldest voice). A beat with
// tuser = 1 carries one signed sample per slot; the active ones are summed onto 128,
// clamped to 0..255, and every voice steps its address and counts down, finished
// voices leaving the table with the rest kept in order. Every input beat yields one
// output beat with the mixed byte (128 for play beats), the voice count and each
// slot's next fetch address (zero for empty slots). The controller first captures
// the beat, then runs the mix/compaction datapath and loads the output register.
// The next beat is taken while the result waits; a held output register stalls
// the execute step until it drains.
module voice_queue_sample_mixer_unit
    import vqsm_pkg::*;
#(
    parameter int VOICES    = VOICES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_address[19:0], length[51:20], sample_0..sample_7[115:52], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mixed_sample[7:0], active_voices[11:8], fetch_address_0..7[171:12], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    dp_cmd_t cmd;

    vqsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    vqsm_datapath #(
        .VOICES    (VOICES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

@@ rtl/core/vqsm_checker.sv @@
module vqsm_checker
    import vqsm_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int FETCH_LO = MIX_W + CNT_W;

    // held output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // one item executing at a time: no beat taken right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is executing");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[MIX_W +: CNT_W] <= CNT_W'(VOICES))
        else $error("voice count above table size");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[MIX_W +: CNT_W] == '0
            |-> m_tdata[FETCH_LO +: SLOTS * ADDR_OUT_W] == '0)
        else $error("empty table reports a fetch address");

endmodule

bind voice_queue_sample_mixer_unit vqsm_checker #(
    .VOICES (VOICES)
) u_vqsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/voice_queue_sample_mixer_unit_tb.sv @@
module voice_queue_sample_mixer_unit_tb
    import vqsm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 600;

    typedef struct packed {
        logic                               mode;
        logic [ADDR_OUT_W-1:0]              addr;
        logic [LEN_W-1:0]                   len;
        logic [SLOTS-1:0][SAMPLE_W-1:0]     smp;
    } voice_cmd_t;

    // field order matches m_tdata, mixed_sample in the low bits
    typedef struct packed {
        logic [SLOTS-1:0][ADDR_OUT_W-1:0]   fetch;
        logic [CNT_W-1:0]                   active;
        logic [MIX_W-1:0]                   mixed;
    } mix_result_t;

    typedef struct packed {
        voice_cmd_t                         cmd;
        logic                               fixed;
        logic [MIX_W-1:0]                   e_mix;
        logic [CNT_W-1:0]                   e_cnt;
        logic [ADDR_OUT_W-1:0]              e_fetch0;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = MODE_PLAY;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // voice table copy
    logic [ADDR_OUT_W-1:0]  voice_addr [SLOTS];
    logic [LEN_W-1:0]       voice_left [SLOTS];
    int                     voice_cnt;

    mix_result_t            mix_expected_q [$];
    dir_row_t               dir_rows [$];

    int tx_idle_pct = 9;
    int rx_idle_pct = 77;
    int mismatches = 0;
    int n_checked = 0;
    int n_beats = 0;
    int n_mix = 0;
    int n_clip = 0;
    int peak_voices = 0;

    voice_queue_sample_mixer_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("timeout, %0d results outstanding", mix_expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic void remove_voice(input int k);
        int j;
        for (j = k; j + 1 < voice_cnt; j++)
        begin
            voice_addr[j] = voice_addr[j + 1];
            voice_left[j] = voice_left[j + 1];
        end
        voice_cnt--;
        voice_addr[voice_cnt] = '0;
        voice_left[voice_cnt] = '0;
    endfunction

    function automatic mix_result_t predict_mix(input voice_cmd_t cmd);
        mix_result_t r;
        int          sum;
        int          i;
        r = '0;
        r.mixed = MIX_W'(MID_LEVEL);
        if (cmd.mode == MODE_PLAY)
        begin
            if (cmd.len >= LEN_W'(MIN_LEN))
            begin
                if (voice_cnt >= VOICES_DEF)
                    remove_voice(0);
                voice_addr[voice_cnt] = cmd.addr;
                voice_left[voice_cnt] = cmd.len - 1'b1;
                voice_cnt++;
            end
        end
        else
        begin
            n_mix++;
            sum = MID_LEVEL;
            for (i = 0; i < voice_cnt; i++)
                sum += int'($signed(cmd.smp[i]));
            if (sum > TOP_LEVEL || sum < 0)
                n_clip++;
            if (sum > TOP_LEVEL)
                sum = TOP_LEVEL;
            if (sum < 0)
                sum = 0;
            r.mixed = MIX_W'(sum);
            // adjacent finished voices both leave; the one shifted in is not skipped
            i = 0;
            while (i < voice_cnt)
            begin
                voice_addr[i] = voice_addr[i] + 1'b1;
                voice_left[i] = voice_left[i] - 1'b1;
                if (voice_left[i] == '0)
                    remove_voice(i);
                else
                    i++;
            end
        end
        if (voice_cnt > peak_voices)
            peak_voices = voice_cnt;
        r.active = CNT_W'(voice_cnt);
        for (i = 0; i < SLOTS; i++)
            r.fetch[i] = (i < voice_cnt) ? voice_addr[i] : '0;
        return r;
    endfunction

    task automatic send_cmd(input voice_cmd_t cmd, input logic fixed, input mix_result_t fixed_res);
        logic [IN_DATA_W-1:0] beat;
        mix_result_t          r;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        beat = '0;
        beat[ADDR_OUT_W-1:0] = cmd.addr;
        beat[ADDR_OUT_W +: LEN_W] = cmd.len;
        beat[ADDR_OUT_W + LEN_W +: SLOTS * SAMPLE_W] = cmd.smp;
        s_tdata  <= beat;
        s_tuser  <= cmd.mode;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        n_beats++;
        r = predict_mix(cmd);
        mix_expected_q.push_back(fixed ? fixed_res : r);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mix_expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return LEN_W'($urandom_range(0, 1));
        else if (pick < 88)
            return LEN_W'($urandom_range(2, 24));
        else if (pick < 96)
            return LEN_W'($urandom_range(25, 300));
        return LEN_W'($urandom);
    endfunction

    function automatic voice_cmd_t rand_cmd(input logic play);
        voice_cmd_t cmd;
        int         shape;
        int         i;
        cmd.mode = play ? MODE_PLAY : MODE_MIX;
        if ($urandom_range(0, 9) == 0)
            cmd.addr = 20'hFFFFF - ADDR_OUT_W'($urandom_range(0, 3));
        else
            cmd.addr = ADDR_OUT_W'($urandom);
        cmd.len = play ? rand_len() : LEN_W'($urandom);
        shape = $urandom_range(0, 9);
        for (i = 0; i < SLOTS; i++)
        begin
            if (shape < 6)
                cmd.smp[i] = SAMPLE_W'($urandom);
            else if (shape < 9)
                cmd.smp[i] = SAMPLE_W'($urandom_range(0, 12) - 6);
            else
                cmd.smp[i] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
        end
        return cmd;
    endfunction

    always @(posedge clk)
    begin : rx_check
        mix_result_t want;
        mix_result_t got;
        int          k;
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[OUT_FIELDS_W-1:0];
            if (mix_expected_q.size() == 0)
            begin
                $error("unexpected result beat %h", got);
                mismatches++;
            end
            else
            begin
                want = mix_expected_q.pop_front();
                n_checked++;
                if (got.mixed !== want.mixed)
                begin
                    $error("mixed_sample: expected %0d, got %0d", want.mixed, got.mixed);
                    mismatches++;
                end
                if (got.active !== want.active)
                begin
                    $error("active_voices: expected %0d, got %0d", want.active, got.active);
                    mismatches++;
                end
                for (k = 0; k < SLOTS; k++)
                begin
                    if (got.fetch[k] !== want.fetch[k])
                    begin
                        $error("fetch_address_%0d: expected %h, got %h",
                               k, want.fetch[k], got.fetch[k]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        mix_result_t fixed_res;
        dir_row_t    row;
        int          p;
        int          n;
        int          burst;

        for (n = 0; n < SLOTS; n++)
        begin
            voice_addr[n] = '0;
            voice_left[n] = '0;
        end
        voice_cnt = 0;

        // mode, addr, len, samples (slot 0 lowest), fixed, mixed, count, fetch 0
        // empty table: samples ignored
        dir_rows.push_back({MODE_MIX, 20'h00000, 32'h0, {8{8'h7F}}, 1'b1, 8'd128, 4'd0, 20'h0});
        // short lengths ignored
        dir_rows.push_back({MODE_PLAY, 20'h00005, 32'h0, {8{8'h7F}}, 1'b1, 8'd128, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'hABCDE, 32'h1, {8{8'h00}}, 1'b1, 8'd128, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'hFFFFF, 32'h3, {8{8'h00}}, 1'b1, 8'd128, 4'd1,
                            20'hFFFFF});
        // address wraps, top clamp edge, unused slots and play fields ignored
        dir_rows.push_back({MODE_MIX, 20'hFFFFF, 32'hFFFFFFFF, {{7{8'h80}}, 8'h7F}, 1'b1,
                            8'd255, 4'd1, 20'h0});
        // bottom edge, voice finishes
        dir_rows.push_back({MODE_MIX, 20'h00000, 32'h0, {{7{8'h7F}}, 8'h80}, 1'b1,
                            8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00010, 32'h2, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00020, 32'hFFFFFFFF, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00030, 32'h2, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00040, 32'h2, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00050, 32'h4, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00060, 32'h80000000, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00070, 32'h5, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00080, 32'h2, 64'h0, 1'b0, 8'd0, 4'd0, 20'h0});
        // full table drops the oldest
        dir_rows.push_back({MODE_PLAY, 20'h00090, 32'h6, {8{8'h7F}}, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_MIX, 20'h00000, 32'h0, {8{8'h7F}}, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_MIX, 20'h00000, 32'h0, {8{8'h80}}, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_MIX, 20'h00000, 32'h0, 64'h01FF10F020E005FB, 1'b0,
                            8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_PLAY, 20'h00000, 32'h2, {8{8'h80}}, 1'b0, 8'd0, 4'd0, 20'h0});
        dir_rows.push_back({MODE_MIX, 20'h5A5A5, 32'hA5A5A5A5, 64'hFD03FE0201FF7F80, 1'b0,
                            8'd0, 4'd0, 20'h0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            fixed_res = '0;
            fixed_res.mixed = row.e_mix;
            fixed_res.active = row.e_cnt;
            fixed_res.fetch[0] = row.e_fetch0;
            send_cmd(row.cmd, row.fixed, fixed_res);
        end
        drain_results();

        fixed_res = '0;
        for (p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 9 : (p == 1) ? 77 : 0;
            rx_idle_pct = (p == 0) ? 77 : (p == 1) ? 9 : 0;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    // burst of plays to fill the table
                    burst = $urandom_range(5, 10);
                    repeat (burst)
                        send_cmd(rand_cmd(1'b1), 1'b0, fixed_res);
                    n += burst;
                end
                else
                begin
                    send_cmd(rand_cmd($urandom_range(0, 99) < 25), 1'b0, fixed_res);
                    n++;
                end
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("%0d beats sent, %0d results checked: %0d mixes, %0d clamped, peak %0d voices,",
                 n_beats, n_checked, n_mix, n_clip, peak_voices);
        $display("under sender-heavy, receiver-heavy and back-to-back idling.");
        if (mismatches == 0 && mix_expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
